>>> sv/wwgs_pkg.sv
// wwgs_pkg: shared types and constants for the wireworld generation step unit
// cell codes, item structs, window layout and configuration register indexes
// no dependencies
package wwgs_pkg;

    localparam int CELL_W      = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int WIN_W       = 9 * CELL_W;

    localparam logic [CELL_W-1:0] CELL_EMPTY     = 2'd0;
    localparam logic [CELL_W-1:0] CELL_HEAD      = 2'd1;
    localparam logic [CELL_W-1:0] CELL_TAIL      = 2'd2;
    localparam logic [CELL_W-1:0] CELL_CONDUCTOR = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        logic [CELL_W-1:0] cell_state;
        logic              flush;
    } cell_item_t;

    typedef struct packed {
        logic [CELL_W-1:0] next_state;
        logic              last_of_frame;
    } result_item_t;

    // three columns of three cells, left column in the low bits,
    // top row lowest within a column
    typedef logic [WIN_W-1:0] window_t;

    // one line-store word: cell from two rows back above the cell from the row above
    typedef struct packed {
        logic [CELL_W-1:0] older;
        logic [CELL_W-1:0] prev;
    } line_word_t;

endpackage

>>> sv/wwgs_rule.sv
// wwgs_rule: wireworld next-state rule over a 3x3 window
// counts head cells around the center and applies the transition table
// depends on wwgs_pkg
module wwgs_rule (
    input  wwgs_pkg::window_t           window,
    output logic [wwgs_pkg::CELL_W-1:0] next_state
);
    import wwgs_pkg::*;

    logic [3:0]        heads;
    logic [CELL_W-1:0] center;

    always_comb
    begin
        heads = 4'd0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4 && window[i*CELL_W +: CELL_W] == CELL_HEAD)
            begin
                heads = heads + 4'd1;
            end
        end
    end

    assign center = window[4*CELL_W +: CELL_W];

    always_comb
    begin
        case (center)
            CELL_HEAD:      next_state = CELL_TAIL;
            CELL_TAIL:      next_state = CELL_CONDUCTOR;
            CELL_CONDUCTOR: next_state = (heads == 4'd1 || heads == 4'd2) ?
                                         CELL_HEAD : CELL_CONDUCTOR;
            default:        next_state = CELL_EMPTY;
        endcase
    end

endmodule

>>> sv/wireworld_generation_step_unit.sv
// wireworld_generation_step_unit: streaming wireworld generation step
// line store, 3x3 window, result register; depends on wwgs_pkg and wwgs_rule
//
// Usage:
//   Cells of one generation enter on the cell channel in raster order, one
//   item per accepted cycle, followed by frame_width+1 padding items (flush
//   set). The first frame_width+1 items of a generation give no result, every
//   later item gives one next-generation cell on the result channel, with
//   last_of_frame set on the final cell. The block then starts the next
//   generation on its own.
//   Timing: an item is taken into the input stage, reads the line store there,
//   and its result, if any, is registered as it leaves that stage. One item per
//   cycle is sustained while results are not stalled; the line store is one
//   read port and one write port, read in the input stage and written as the
//   item leaves it, with a bypass for back-to-back items on the same column.
//   Stalls: when the result register is full and stalled, an item that gives
//   a result waits in the input stage and cell_stall goes high; items that
//   give no result pass on.
//   Reset clears the positions, the window and both pipeline stages and sets
//   both frame registers to 1024 (capped at the maximum). Line store contents
//   need no clearing: every entry is written within a generation before it is
//   read. A write to frame_width or frame_height restarts the generation and
//   must only happen while the block is idle.
module wireworld_generation_step_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cell_valid,
    output logic                             cell_stall,
    input  wwgs_pkg::cell_item_t             cell_item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output wwgs_pkg::result_item_t           result_item,
    input  logic                             wr_en,
    input  logic [wwgs_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [wwgs_pkg::CFG_DATA_W-1:0]  wr_data
);
    import wwgs_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);
    localparam int W_RESET = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
    localparam int H_RESET = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

    typedef struct packed {
        logic has_mid;
        logic has_top;
        logic first_col;
        logic emit;
        logic last;
        logic fwd;
    } stage_ctl_t;

    // frame size, stored already clamped
    logic [WCNT_W-1:0] width_reg;
    logic [HCNT_W-1:0] height_reg;
    logic [WCNT_W-1:0] width_clamped;
    logic [HCNT_W-1:0] height_clamped;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;

    logic              s1_valid_reg;
    stage_ctl_t        s1_ctl_reg, s1_ctl_next;
    logic [CELL_W-1:0] s1_cell_reg, s1_cell_next;
    logic [COL_W-1:0]  s1_col_reg;
    line_word_t        s1_fwd_data_reg;

    line_word_t        line_mem [MAX_WIDTH];
    line_word_t        line_rd_reg;

    window_t           window_reg, window_next;
    window_t           view;

    logic              result_valid_reg;
    result_item_t      result_reg;
    logic [CELL_W-1:0] rule_out;

    logic              accept, s1_go, cfg_restart;
    line_word_t        line_word, wr_word;
    logic [CELL_W-1:0] mid, top;
    logic [3*CELL_W-1:0] triple;
    logic              row_is_end;

    // configuration clamp
    always_comb
    begin
        if (wr_data == '0)
        begin
            width_clamped  = WCNT_W'(1);
            height_clamped = HCNT_W'(1);
        end
        else
        begin
            width_clamped  = (32'(wr_data) > 32'(MAX_WIDTH)) ?
                             WCNT_W'(MAX_WIDTH) : WCNT_W'(wr_data);
            height_clamped = (32'(wr_data) > 32'(MAX_HEIGHT)) ?
                             HCNT_W'(MAX_HEIGHT) : HCNT_W'(wr_data);
        end
    end

    assign cfg_restart = wr_en && (wr_index == REG_FRAME_WIDTH ||
                                   wr_index == REG_FRAME_HEIGHT);

    // handshake
    assign s1_go      = s1_valid_reg &&
                        (!s1_ctl_reg.emit || !result_valid_reg || !result_stall);
    assign cell_stall = s1_valid_reg && !s1_go;
    assign accept     = cell_valid && !cell_stall;

    // input stage: classify the item at the current position
    assign row_is_end = 32'(row_reg) == 32'(height_reg) + 32'd1;

    always_comb
    begin
        s1_cell_next = cell_item.cell_state;
        if (cell_item.flush || 32'(row_reg) >= 32'(height_reg))
        begin
            s1_cell_next = CELL_EMPTY;
        end
        s1_ctl_next.has_mid   = row_reg != '0;
        s1_ctl_next.has_top   = 32'(row_reg) >= 32'd2;
        s1_ctl_next.first_col = col_reg == '0;
        if (col_reg == '0)
        begin
            s1_ctl_next.emit = 32'(row_reg) >= 32'd2;
        end
        else
        begin
            s1_ctl_next.emit = row_reg != '0 && 32'(row_reg) <= 32'(height_reg);
        end
        s1_ctl_next.last = col_reg == '0 && row_is_end;
        // same column written by the item leaving the input stage
        s1_ctl_next.fwd  = s1_go && s1_col_reg == col_reg;

        col_next = col_reg;
        row_next = row_reg;
        if (row_is_end)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (32'(col_reg) + 32'd1 == 32'(width_reg))
        begin
            col_next = '0;
            row_next = row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
        end
    end

    // second stage: line store data, window shift
    always_comb
    begin
        line_word    = s1_ctl_reg.fwd ? s1_fwd_data_reg : line_rd_reg;
        mid          = s1_ctl_reg.has_mid ? line_word.prev : CELL_EMPTY;
        top          = s1_ctl_reg.has_top ? line_word.older : CELL_EMPTY;
        wr_word.older = mid;
        wr_word.prev  = s1_cell_reg;
        triple       = {s1_cell_reg, mid, top};
        if (s1_ctl_reg.first_col)
        begin
            // close the row above with an empty right edge, start anew
            view        = {{(3*CELL_W){1'b0}}, window_reg[WIN_W-1:3*CELL_W]};
            window_next = {triple, {(6*CELL_W){1'b0}}};
        end
        else
        begin
            window_next = {triple, window_reg[WIN_W-1:3*CELL_W]};
            view        = window_next;
        end
    end

    wwgs_rule u_rule (
        .window     (view),
        .next_state (rule_out)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg        <= WCNT_W'(W_RESET);
            height_reg       <= HCNT_W'(H_RESET);
            col_reg          <= '0;
            row_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            s1_ctl_reg       <= '0;
            window_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_index == REG_FRAME_WIDTH)
            begin
                width_reg <= width_clamped;
            end
            if (wr_en && wr_index == REG_FRAME_HEIGHT)
            begin
                height_reg <= height_clamped;
            end

            if (cfg_restart)
            begin
                col_reg    <= '0;
                row_reg    <= '0;
                window_reg <= '0;
            end
            else
            begin
                if (accept)
                begin
                    col_reg <= col_next;
                    row_reg <= row_next;
                end
                if (s1_go)
                begin
                    window_reg <= window_next;
                end
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_ctl_reg   <= s1_ctl_next;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go && s1_ctl_reg.emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload and line store
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cell_reg     <= s1_cell_next;
            s1_col_reg      <= col_reg;
            s1_fwd_data_reg <= wr_word;
            line_rd_reg     <= line_mem[col_reg];
        end
        if (s1_go)
        begin
            line_mem[s1_col_reg] <= wr_word;
        end
        if (s1_go && s1_ctl_reg.emit)
        begin
            result_reg.next_state    <= rule_out;
            result_reg.last_of_frame <= s1_ctl_reg.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    // assertions
    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < 32'(width_reg))
        else $error("column position outside the frame");

    a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cell_stall |-> s1_valid_reg && s1_ctl_reg.emit && result_valid_reg)
        else $error("input stalled without a blocked result");

    // the wrap from the end of one generation to the next also repeats column zero
    a_fwd_narrow_frame: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_ctl_reg.fwd |-> width_reg == WCNT_W'(1) || !s1_ctl_reg.has_mid)
        else $error("line store bypass outside a one-cell frame or a generation start");

    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(s1_valid_reg && s1_ctl_reg.emit))
        else $error("result appeared without an item leaving the input stage");

endmodule

>>> sim/testbench.sv
// testbench: self-checking bench for wireworld_generation_step_unit
// streams random and directed generations, predicts each next-generation cell
// depends on wwgs_pkg and the unit's rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wwgs_pkg::*;

    localparam int MAX_W = 1024;
    localparam int MAX_H = 1024;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cell_valid = 1'b0;
    logic                   cell_stall;
    cell_item_t             cell_item = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_item_t           result_item;
    logic                   wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] wr_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]  wr_data = '0;

    // predicted block state
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [CELL_W-1:0]     row_above_store [MAX_W];
    logic [CELL_W-1:0]     row_two_up_store [MAX_W];
    window_t               window_now;
    int unsigned           col_pos;
    int unsigned           row_pos;

    result_item_t pending_next_cells [$];
    result_item_t want_item;
    int unsigned  fail_count = 0;
    int unsigned  cells_sent = 0;
    bit           idle_bursts_on = 1'b1;
    int unsigned  stall_left = 0;

    always #5 clk = ~clk;

    wireworld_generation_step_unit #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_valid   (cell_valid),
        .cell_stall   (cell_stall),
        .cell_item    (cell_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    function automatic int unsigned frame_extent(input logic [CFG_DATA_W-1:0] v,
                                                 input int unsigned top);
        if (v == 0)
            return 1;
        return (v > top) ? top : v;
    endfunction

    // window: column-major, left column lowest, top row lowest in a column
    function automatic logic [CELL_W-1:0] wireworld_rule(input window_t view);
        int heads;
        heads = 0;
        for (int col = 0; col < 3; col++)
            for (int row = 0; row < 3; row++)
                if ((col != 1 || row != 1)
                    && view[(col * 3 + row) * CELL_W +: CELL_W] == CELL_HEAD)
                    heads++;
        case (view[4 * CELL_W +: CELL_W])
            CELL_HEAD:      return CELL_TAIL;
            CELL_TAIL:      return CELL_CONDUCTOR;
            CELL_CONDUCTOR: return (heads == 1 || heads == 2) ? CELL_HEAD : CELL_CONDUCTOR;
            default:        return CELL_EMPTY;
        endcase
    endfunction

    function automatic void advance_generation(input cell_item_t it, output bit emits,
                                               output result_item_t res);
        int unsigned           w;
        int unsigned           h;
        int unsigned           r;
        int unsigned           c;
        logic [CELL_W-1:0]     v;
        logic [CELL_W-1:0]     top;
        logic [CELL_W-1:0]     mid;
        logic [3*CELL_W-1:0]   column;
        window_t               view;
        bit                    is_last;
        w = frame_extent(width_reg, MAX_W);
        h = frame_extent(height_reg, MAX_H);
        r = row_pos;
        c = col_pos;
        if (c >= w || r > h + 1)
        begin
            r = 0;
            c = 0;
        end
        // flush items and padding rows count as empty cells
        v = (it.flush || r >= h) ? CELL_EMPTY : it.cell_state;
        top = (r >= 2) ? row_two_up_store[c] : CELL_EMPTY;
        mid = (r >= 1) ? row_above_store[c] : CELL_EMPTY;
        row_two_up_store[c] = mid;
        row_above_store[c] = v;
        column = {v, mid, top};
        if (c == 0)
        begin
            // close the row above with an empty right edge
            view = {{(3*CELL_W){1'b0}}, window_now[WIN_W-1:3*CELL_W]};
            emits = (r >= 2);
            is_last = (r == h + 1);
            window_now = {column, {(6*CELL_W){1'b0}}};
        end
        else
        begin
            window_now = {column, window_now[WIN_W-1:3*CELL_W]};
            view = window_now;
            emits = (r >= 1 && r <= h);
            is_last = 1'b0;
        end
        if (r == h + 1)
        begin
            r = 0;
            c = 0;
        end
        else
        begin
            c++;
            if (c == w)
            begin
                c = 0;
                r++;
            end
        end
        col_pos = c;
        row_pos = r;
        res.next_state = wireworld_rule(view);
        res.last_of_frame = is_last;
    endfunction

    function automatic logic [CELL_W-1:0] random_cell();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 3)
            return CELL_EMPTY;
        if (pick < 7)
            return CELL_HEAD;
        if (pick < 10)
            return CELL_TAIL;
        return CELL_CONDUCTOR;
    endfunction

    function automatic cell_item_t make_cell(input logic [CELL_W-1:0] state, input logic flush);
        cell_item_t it;
        it.cell_state = state;
        it.flush = flush;
        return it;
    endfunction

    // starts and ends at a falling edge
    task automatic send_cell(input cell_item_t it);
        bit           emits;
        result_item_t res;
        if (idle_bursts_on && $urandom_range(0, 5) == 0)
        begin
            cell_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        cell_item = it;
        cell_valid = 1'b1;
        @(posedge clk);
        while (cell_stall)
            @(posedge clk);
        advance_generation(it, emits, res);
        if (emits)
            pending_next_cells.push_back(res);
        cells_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_idle();
        cell_valid = 1'b0;
        while (pending_next_cells.size() != 0)
            @(posedge clk);
        // items that give no result may still sit in the pipeline
        repeat (6) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index, input int unsigned value);
        wr_en = 1'b1;
        wr_index = index;
        wr_data = value[CFG_DATA_W-1:0];
        @(negedge clk);
        wr_en = 1'b0;
        if (index == REG_FRAME_WIDTH)
            width_reg = value[CFG_DATA_W-1:0];
        else
            height_reg = value[CFG_DATA_W-1:0];
        col_pos = 0;
        row_pos = 0;
        window_now = '0;
    endtask

    task automatic set_frame(input int unsigned w, input int unsigned h);
        wait_for_idle();
        write_register(REG_FRAME_WIDTH, w);
        write_register(REG_FRAME_HEIGHT, h);
    endtask

    // one generation: frame cells, a row and a cell of padding; cut short if broken
    task automatic send_generation(input bit broken);
        int unsigned w;
        int unsigned h;
        int unsigned cells;
        int unsigned total;
        cell_item_t  it;
        w = frame_extent(width_reg, MAX_W);
        h = frame_extent(height_reg, MAX_H);
        cells = w * h;
        total = cells + w + 1;
        if (broken)
            total = $urandom_range(1, total - 1);
        for (int unsigned k = 0; k < total; k++)
        begin
            it.cell_state = random_cell();
            if (k < cells)
                it.flush = ($urandom_range(0, 19) == 0);
            else
                it.flush = ($urandom_range(0, 7) != 0);
            send_cell(it);
        end
    endtask

    // a few items under the reset size, then a write must restart the frame
    task automatic test_restart_mid_generation();
        for (int k = 0; k < 12; k++)
            send_cell(make_cell(random_cell(), 1'($urandom_range(0, 1))));
    endtask

    task automatic test_directed_patterns();
        set_frame(3, 3);
        send_cell(make_cell(CELL_HEAD, 1'b0));
        send_cell(make_cell(CELL_CONDUCTOR, 1'b0));
        send_cell(make_cell(CELL_HEAD, 1'b0));
        send_cell(make_cell(CELL_TAIL, 1'b0));
        send_cell(make_cell(CELL_CONDUCTOR, 1'b0));
        send_cell(make_cell(CELL_CONDUCTOR, 1'b0));
        send_cell(make_cell(CELL_HEAD, 1'b0));
        send_cell(make_cell(CELL_HEAD, 1'b0));
        // flush inside the frame hides this head
        send_cell(make_cell(CELL_HEAD, 1'b1));
        // padding, some without flush and a nonempty cell
        send_cell(make_cell(CELL_CONDUCTOR, 1'b0));
        send_cell(make_cell(CELL_HEAD, 1'b1));
        send_cell(make_cell(CELL_TAIL, 1'b0));
        send_cell(make_cell(CELL_EMPTY, 1'b1));
        set_frame(4, 1);
        send_cell(make_cell(CELL_CONDUCTOR, 1'b0));
        send_cell(make_cell(CELL_HEAD, 1'b0));
        send_cell(make_cell(CELL_CONDUCTOR, 1'b0));
        send_cell(make_cell(CELL_CONDUCTOR, 1'b0));
        send_cell(make_cell(CELL_HEAD, 1'b0));
        send_cell(make_cell(CELL_CONDUCTOR, 1'b1));
        send_cell(make_cell(CELL_EMPTY, 1'b0));
        send_cell(make_cell(CELL_TAIL, 1'b1));
        send_cell(make_cell(CELL_CONDUCTOR, 1'b0));
    endtask

    task automatic test_random_generations();
        int unsigned start;
        int unsigned w;
        int unsigned h;
        int unsigned rounds;
        start = cells_sent;
        while (cells_sent - start < 250)
        begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0)
                w = 0;
            if ($urandom_range(0, 15) == 0)
                h = 0;
            idle_bursts_on = ($urandom_range(0, 3) != 0);
            set_frame(w, h);
            rounds = $urandom_range(1, 3);
            for (int unsigned g = 0; g < rounds && cells_sent - start < 250; g++)
                send_generation(g == rounds - 1 && $urandom_range(0, 5) == 0);
        end
    endtask

    task automatic test_frame_size_extremes();
        idle_bursts_on = 1'b1;
        set_frame(0, 0);
        send_generation(1'b0);
        set_frame(1, 40);
        send_generation(1'b0);
        set_frame(40, 1);
        send_generation(1'b0);
        // zero clips to one, too large to the maximum; only frame starts are sent
        set_frame(0, 2047);
        for (int k = 0; k < 20; k++)
            send_cell(make_cell(random_cell(), 1'b0));
        set_frame(2047, 0);
        for (int k = 0; k < 20; k++)
            send_cell(make_cell(random_cell(), 1'b0));
    endtask

    task automatic test_back_to_back();
        idle_bursts_on = 1'b0;
        set_frame(5, 4);
        repeat (3) send_generation(1'b0);
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (idle_bursts_on && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 3);
        result_stall = (stall_left > 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_next_cells.size() == 0)
            begin
                $display("%0t: result with none pending: next_state %0d last_of_frame %0b",
                         $time, result_item.next_state, result_item.last_of_frame);
                fail_count++;
            end
            else
            begin
                want_item = pending_next_cells.pop_front();
                if (result_item.next_state !== want_item.next_state)
                begin
                    $display("%0t: next_state expected %0d got %0d",
                             $time, want_item.next_state, result_item.next_state);
                    fail_count++;
                end
                if (result_item.last_of_frame !== want_item.last_of_frame)
                begin
                    $display("%0t: last_of_frame expected %0b got %0b",
                             $time, want_item.last_of_frame, result_item.last_of_frame);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #(10_000_000);
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        width_reg = 11'd1024;
        height_reg = 11'd1024;
        for (int k = 0; k < MAX_W; k++)
        begin
            row_above_store[k] = CELL_EMPTY;
            row_two_up_store[k] = CELL_EMPTY;
        end
        window_now = '0;
        col_pos = 0;
        row_pos = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        test_restart_mid_generation();
        test_directed_patterns();
        test_random_generations();
        test_frame_size_extremes();
        test_back_to_back();
        wait_for_idle();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

>>> files.f
sv/wwgs_pkg.sv
sv/wwgs_rule.sv
sv/wireworld_generation_step_unit.sv
sim/testbench.sv
